### rtl/core/tlbc_pkg.sv
`timescale 1ns / 1ps

package tlbc_pkg;

  localparam int SLOT_BITS = 4;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_ADD    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_RESP
  } ctrl_state_t;

  // capture: latch request and tag compare; exec: search and update state;
  // respond: result registers are on the ports
  typedef struct packed {
    logic capture;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

endpackage

### rtl/core/tlbc_ram.sv
`timescale 1ns / 1ps

module tlbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tlbc_find.sv
`timescale 1ns / 1ps

// First set bit of vec at or after start_idx, wrapping around.
module tlbc_find #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  logic [N-1:0]  vec,
  input  logic [IW-1:0] start_idx,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic [N-1:0]  upper;
  logic [IW-1:0] idx_upper;
  logic [IW-1:0] idx_any;

  always_comb begin
    idx_upper = '0;
    idx_any   = '0;
    for (int i = 0; i < N; i++) begin
      upper[i] = vec[i] && (IW'(i) >= start_idx);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (upper[i]) begin
        idx_upper = IW'(i);
      end
      if (vec[i]) begin
        idx_any = IW'(i);
      end
    end
    found = |vec;
    idx   = (|upper) ? idx_upper : idx_any;
  end

endmodule

### rtl/core/tlbc_ctrl.sv
`timescale 1ns / 1ps

module tlbc_ctrl
  import tlbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_SEL;
        end
      end
      ST_SEL: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        cmd.respond = 1'b1;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_SEL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/tlbc_dp.sv
`timescale 1ns / 1ps

module tlbc_dp
  import tlbc_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic                  func,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [FRAME_BITS-1:0] frame_in,
  input  logic                  readonly_in,
  input  logic                  is_write,
  output logic                  hit,
  output logic [FRAME_BITS-1:0] frame_out,
  output logic [SLOT_BITS-1:0]  slot,
  output logic                  readonly_out
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);

  // request registers
  logic                  req_func;
  logic [PAGE_BITS-1:0]  req_page;
  logic [FRAME_BITS-1:0] req_frame;
  logic                  req_ro;
  logic                  req_wr;
  logic [ENTRIES-1:0]    match;

  // entry state
  logic [PAGE_BITS-1:0]  tags [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [ENTRIES-1:0]    ro_bits;
  logic [ENTRIES-1:0]    refd;
  logic [IW-1:0]         hand;
  logic [FW-1:0]         fill;

  // result registers
  logic                  hit_q;
  logic [IW-1:0]         slot_q;
  logic                  ro_q;

  logic [ENTRIES-1:0]    search_vec;
  logic                  found;
  logic [IW-1:0]         found_idx;

  logic                  filling;
  logic [IW-1:0]         sel;
  logic [IW-1:0]         victim;
  logic [IW-1:0]         victim_inc;
  logic [ENTRIES-1:0]    sweep_clr;
  logic                  do_write;
  logic [IW+SLOT_BITS-1:0] slot_ext;
  logic [FRAME_BITS-1:0] ram_rdata;

  // lookup searches the tag matches, a full add searches for an unreferenced slot
  assign search_vec = (req_func == FUNC_LOOKUP) ? match : ~refd;

  tlbc_find #(
    .N  (ENTRIES),
    .IW (IW)
  ) u_find (
    .vec       (search_vec),
    .start_idx (hand),
    .found     (found),
    .idx       (found_idx)
  );

  assign filling    = (fill < FW'(ENTRIES));
  assign victim     = found ? found_idx : hand;
  assign victim_inc = (victim == IW'(ENTRIES - 1)) ? '0 : victim + 1'b1;
  assign sel        = (req_func == FUNC_LOOKUP) ? found_idx
                    : (filling ? fill[IW-1:0] : victim);
  assign do_write   = cmd.exec && (req_func == FUNC_ADD);

  // referenced bits passed over by the sweep: circular range [hand, victim),
  // or every slot when all were referenced
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found) begin
        sweep_clr[i] = 1'b1;
      end else if (victim >= hand) begin
        sweep_clr[i] = (IW'(i) >= hand) && (IW'(i) < victim);
      end else begin
        sweep_clr[i] = (IW'(i) >= hand) || (IW'(i) < victim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func  <= func;
      req_page  <= page;
      req_frame <= frame_in;
      req_ro    <= readonly_in;
      req_wr    <= is_write;
      for (int i = 0; i < ENTRIES; i++) begin
        match[i] <= valid[i] && (tags[i] == page);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      refd  <= '0;
      hand  <= '0;
      fill  <= '0;
    end else if (cmd.exec) begin
      if (req_func == FUNC_LOOKUP) begin
        if (found) begin
          refd[found_idx] <= 1'b1;
          hand            <= found_idx;
        end
      end else if (filling) begin
        valid[sel] <= 1'b1;
        refd[sel]  <= 1'b1;
        fill       <= fill + 1'b1;
      end else begin
        refd       <= (refd & ~sweep_clr) | (ENTRIES'(1) << victim);
        valid[sel] <= 1'b1;
        hand       <= victim_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      tags[sel]    <= req_page;
      ro_bits[sel] <= req_ro;
    end else if (cmd.exec && found && req_wr) begin
      ro_bits[found_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (req_func == FUNC_LOOKUP) begin
        hit_q  <= found;
        slot_q <= found ? found_idx : '0;
        ro_q   <= found && ro_bits[found_idx] && !req_wr;
      end else begin
        hit_q  <= 1'b0;
        slot_q <= sel;
        ro_q   <= req_ro;
      end
    end
  end

  tlbc_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (ENTRIES)
  ) u_frames (
    .clk   (clk),
    .we    (do_write),
    .waddr (sel),
    .wdata (req_frame),
    .raddr (found_idx),
    .rdata (ram_rdata)
  );

  assign slot_ext     = {{SLOT_BITS{1'b0}}, slot_q};
  assign hit          = hit_q;
  assign frame_out    = hit_q ? ram_rdata : '0;
  assign slot         = slot_ext[SLOT_BITS-1:0];
  assign readonly_out = ro_q;

endmodule

### rtl/core/tlb_clock_replacement.sv
// Fully associative TLB with clock (second-chance) replacement.
// The result strobe (done) rises in the respond state, which follows the
// select state entered when a request is taken. No request is taken in
// select (busy); one may be taken in respond. Tag compare registers at the
// request; the clock search and frame memory read share the select state.
// Reset (rst, synchronous): all slots invalid, hand and fill count zero.
// Results show for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps

module tlb_clock_replacement
  import tlbc_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [FRAME_BITS-1:0] frame_in,
  input  logic                  readonly_in,
  input  logic                  is_write,
  output logic                  done,
  output logic                  hit,
  output logic [FRAME_BITS-1:0] frame_out,
  output logic [SLOT_BITS-1:0]  slot,
  output logic                  readonly_out
);

  ctrl_cmd_t cmd;

  tlbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tlbc_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .page         (page),
    .frame_in     (frame_in),
    .readonly_in  (readonly_in),
    .is_write     (is_write),
    .hit          (hit),
    .frame_out    (frame_out),
    .slot         (slot),
    .readonly_out (readonly_out)
  );

  assign done = cmd.respond;

endmodule

### rtl/core/tlbc_checker.sv
`timescale 1ns / 1ps

module tlbc_checker #(
  parameter int FRAME_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  hit,
  input logic [FRAME_BITS-1:0] frame_out
);

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_req_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("no result two cycles after request");

  a_busy_once: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("busy held too long or result missing");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_miss_frame: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> frame_out == '0)
    else $error("nonzero frame on miss or add");

endmodule

bind tlb_clock_replacement tlbc_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_tlbc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .hit       (hit),
  .frame_out (frame_out)
);
